// ===== hdl/bprm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block peak/RMS meter package
// Field widths, parameter defaults and iteration counts shared by the meter.
// ----------------------------------------------------------------------------
package bprm_pkg;

	localparam int SampleWidth       = 24;  // Q1.23 sample and magnitude width
	localparam int CountWidth        = 17;  // frame count, 1 .. 65536
	localparam int SumWidth          = 63;  // Q17.46 sum of squares
	localparam int SquareWidth       = 2 * SampleWidth;
	localparam int MaxFramesDefault  = 65536;
	localparam int SampleBitsDefault = 24;

	// divide: one quotient bit per dividend bit
	localparam int DivSteps  = SumWidth;
	// root: two radicand bits per step over the square width
	localparam int RootSteps = SquareWidth / 2;
	localparam int StepWidth = $clog2(DivSteps);

endpackage

// ===== hdl/block_peak_rms_meter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block peak and RMS level meter
// Tracks peak magnitude, sum of squares and frame count over a block of
// samples; on the last sample emits peak, floor RMS, count and overflow.
// ----------------------------------------------------------------------------
// After acceptance the serial squarer steps through the magnitude bits up to
//   the top set bit and stops once it sees the multiplier empty.
// A last sample then runs the divide and root steps, and its result loads into
//   the result register once the output is free.
// Input is ready only while idle; a sample past the frame limit skips the squarer.
// Reset (arst_n low, asynchronous): block state and result valid cleared.
// ----------------------------------------------------------------------------
module block_peak_rms_meter #(
	parameter int MAX_FRAMES  = bprm_pkg::MaxFramesDefault,
	parameter int SAMPLE_BITS = bprm_pkg::SampleBitsDefault
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// sample channel
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [bprm_pkg::SampleWidth-1:0]   sample,
	input  logic                               last,
	// result channel
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [bprm_pkg::SampleWidth-1:0]   peak,
	output logic [bprm_pkg::SampleWidth-1:0]   rms,
	output logic [bprm_pkg::CountWidth-1:0]    frame_count,
	output logic                               overflow
);
	import bprm_pkg::*;

	// sequencer states
	localparam logic [2:0] StIdle = 3'd0;  // waiting for a sample
	localparam logic [2:0] StMul  = 3'd1;  // shift-add square into the sum
	localparam logic [2:0] StDiv  = 3'd2;  // sum / count, one bit a cycle
	localparam logic [2:0] StRoot = 3'd3;  // floor sqrt, one root bit a cycle
	localparam logic [2:0] StDone = 3'd4;  // wait for the result register

	localparam int AlignShift = SampleWidth - SAMPLE_BITS;
	localparam int SumPad     = SumWidth - SquareWidth;
	localparam int RootRem    = RootSteps + 2;  // sqrt remainder width
	localparam logic [CountWidth-1:0] MaxCount = CountWidth'(MAX_FRAMES);
	localparam logic [StepWidth-1:0]  DivLast  = StepWidth'(DivSteps - 1);
	localparam logic [StepWidth-1:0]  RootLast = StepWidth'(RootSteps - 1);

	logic [2:0]              state_q;
	logic [StepWidth-1:0]    step_q;
	logic                    last_q;

	// block state
	logic [SampleWidth-1:0]  peak_hold_q;
	logic [SumWidth-1:0]     square_sum_q;   // sum, then quotient, then radicand
	logic [CountWidth-1:0]   sample_count_q;
	logic                    overflow_seen_q;

	// serial squarer operands
	logic [SampleWidth-1:0]  mr_q;           // multiplier, shifts right
	logic [SquareWidth-1:0]  md_q;           // multiplicand, shifts left

	// divider remainder and root datapath
	logic [CountWidth-1:0]   div_rem_q;
	logic [RootRem-1:0]      root_rem_q;
	logic [SampleWidth-1:0]  root_q;

	// result register
	logic                    out_valid_q;
	logic [SampleWidth-1:0]  peak_out_q;
	logic [SampleWidth-1:0]  rms_out_q;
	logic [CountWidth-1:0]   count_out_q;
	logic                    ovf_out_q;

	// magnitude of the incoming sample, left aligned to Q1.23
	logic [SAMPLE_BITS-1:0]  raw;
	logic [SAMPLE_BITS:0]    mag_wide;
	logic [SampleWidth-1:0]  mag;
	logic                    accept;
	logic                    counted;

	assign raw      = sample[SAMPLE_BITS-1:0];
	assign mag_wide = raw[SAMPLE_BITS-1]
		? (((SAMPLE_BITS + 1)'(1)) << SAMPLE_BITS) - {1'b0, raw}
		: {1'b0, raw};
	assign mag      = SampleWidth'(mag_wide) << AlignShift;
	assign accept   = in_valid && in_ready;
	// once the count reaches the limit, further samples only flag overflow
	assign counted  = sample_count_q < MaxCount;

	// divide step: bring down the next dividend bit
	logic [CountWidth:0]     div_trial;
	logic [CountWidth:0]     div_diff;
	logic                    div_ge;
	assign div_trial = {div_rem_q, square_sum_q[SumWidth-1]};
	assign div_diff  = div_trial - {1'b0, sample_count_q};
	assign div_ge    = div_trial >= {1'b0, sample_count_q};

	// root step: bring down two radicand bits, try root*4+1
	logic [RootRem+1:0]      root_trial;
	logic [RootRem+1:0]      root_test;
	logic                    root_ge;
	assign root_trial = {root_rem_q, square_sum_q[SquareWidth-1 -: 2]};
	assign root_test  = {2'b00, root_q, 2'b01};
	assign root_ge    = root_trial >= root_test;

	logic                    out_free;
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= StIdle;
			step_q          <= '0;
			last_q          <= 1'b0;
			peak_hold_q     <= '0;
			square_sum_q    <= '0;
			sample_count_q  <= '0;
			overflow_seen_q <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			// new result loads as the old one leaves
			if (state_q == StDone && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				StIdle: begin
					if (accept) begin
						last_q <= last;
						step_q <= '0;
						if (counted) begin
							if (mag > peak_hold_q) begin
								peak_hold_q <= mag;
							end
							sample_count_q <= sample_count_q + 1'b1;
							state_q        <= StMul;
						end else begin
							overflow_seen_q <= 1'b1;
							state_q         <= last ? StDiv : StIdle;
						end
					end
				end
				StMul: begin
					// stop as soon as no multiplier bits remain
					if (mr_q == '0) begin
						state_q <= last_q ? StDiv : StIdle;
					end else if (mr_q[0]) begin
						square_sum_q <= square_sum_q + {{SumPad{1'b0}}, md_q};
					end
				end
				StDiv: begin
					square_sum_q <= {square_sum_q[SumWidth-2:0], div_ge};
					if (step_q == DivLast) begin
						step_q  <= '0;
						state_q <= StRoot;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				StRoot: begin
					// quotient fits the square width; shift radicand up two bits
					square_sum_q <= {square_sum_q[SumWidth-3:0], 2'b00};
					step_q       <= step_q + 1'b1;
					if (step_q == RootLast) begin
						state_q <= StDone;
					end
				end
				StDone: begin
					if (out_free) begin
						peak_hold_q     <= '0;
						square_sum_q    <= '0;
						sample_count_q  <= '0;
						overflow_seen_q <= 1'b0;
						state_q         <= StIdle;
					end
				end
				default: begin
					state_q <= StIdle;
				end
			endcase
		end
	end

	// datapath registers without reset
	always_ff @(posedge clk) begin
		case (state_q)
			StIdle: begin
				mr_q       <= mag;
				md_q       <= SquareWidth'(mag);
				div_rem_q  <= '0;
				root_rem_q <= '0;
				root_q     <= '0;
			end
			StMul: begin
				mr_q <= mr_q >> 1;
				md_q <= md_q << 1;
			end
			StDiv: begin
				div_rem_q <= div_ge ? div_diff[CountWidth-1:0] : div_trial[CountWidth-1:0];
			end
			StRoot: begin
				root_rem_q <= root_ge ? RootRem'(root_trial - root_test)
				                      : root_trial[RootRem-1:0];
				root_q     <= {root_q[SampleWidth-2:0], root_ge};
			end
			StDone: begin
				if (out_free) begin
					peak_out_q  <= peak_hold_q;
					rms_out_q   <= root_q;
					count_out_q <= sample_count_q;
					ovf_out_q   <= overflow_seen_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign in_ready    = state_q == StIdle;
	assign out_valid   = out_valid_q;
	assign peak        = peak_out_q;
	assign rms         = rms_out_q;
	assign frame_count = count_out_q;
	assign overflow    = ovf_out_q;

	// count never passes the frame limit
	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		sample_count_q <= MaxCount)
		else $error("sample count beyond frame limit");

	// divider never sees a zero count
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == StDiv |-> sample_count_q != '0)
		else $error("divide by zero count");

	// a closing sample stalls the input side
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last |=> !in_ready)
		else $error("input accepted right after last item");

	// a result always covers at least one frame and its rms never exceeds the peak
	a_result_sane: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (frame_count != '0) && (rms <= peak))
		else $error("inconsistent result item");

endmodule
